/* hw/rtl/apt_pkg.sv */
// Shared types, constants and arithmetic helpers of the aging position track table.
package apt_pkg;

  localparam int SLOTS      = 16;
  localparam int FRAC_BITS  = 8;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int COORD_W    = 16;
  localparam int POS_W      = 24;
  localparam int STAMP_W    = 32;
  localparam int ID_W       = 16;
  localparam int KEY_W      = 16;
  localparam int LIFE_W     = 8;
  localparam int SLOT_OUT_W = 4;
  localparam int STATUS_W   = 3;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WIDE_W     = (COORD_W + FRAC_BITS > POS_W) ? COORD_W + FRAC_BITS : POS_W;
  localparam int CALC_W     = WIDE_W + 3;

  localparam logic [LIFE_W-1:0] LIFE_RESET = LIFE_W'(20);

  localparam logic [CFG_IDX_W-1:0] CFG_SCENE_KEY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_Y  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME  = CFG_IDX_W'(2);

  localparam logic signed [CALC_W-1:0] POS_MAX =
    {{(CALC_W - POS_W + 1){1'b0}}, {(POS_W - 1){1'b1}}};
  localparam logic signed [CALC_W-1:0] POS_MIN =
    {{(CALC_W - POS_W + 1){1'b1}}, {(POS_W - 1){1'b0}}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_MSG   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_REFRESH = 3'd0,
    ST_INSERT  = 3'd1,
    ST_STALE   = 3'd2,
    ST_OTHER   = 3'd3,
    ST_FULL    = 3'd4,
    ST_CLEARED = 3'd5
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]           owner;
    logic [STAMP_W-1:0]        last_frame;
    logic signed [POS_W-1:0]   cur_x;
    logic signed [POS_W-1:0]   cur_y;
    logic signed [POS_W-1:0]   cur_z;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;
    logic signed [COORD_W-1:0] goal_z;
  } slot_entry_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [CALC_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[POS_W-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] to_fixed(input logic signed [COORD_W-1:0] g);
    logic signed [CALC_W-1:0] w;
    w = CALC_W'(g) <<< FRAC_BITS;
    return sat_pos(w);
  endfunction

endpackage

/* hw/rtl/apt_if.sv */
// Item and result channel interfaces of the aging position track table.
interface apt_item_if import apt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic [ID_W-1:0]           client_id;
  logic [KEY_W-1:0]          scene_key;
  logic [STAMP_W-1:0]        frame_stamp;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, action, client_id, scene_key, frame_stamp,
                  coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, client_id, scene_key, frame_stamp,
                  coord_x, coord_y, coord_z, output ready);
endinterface

interface apt_result_if import apt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_OUT_W-1:0]   slot;
  logic                    active;
  logic [ID_W-1:0]         owner_id;
  logic signed [POS_W-1:0] smooth_x;
  logic signed [POS_W-1:0] smooth_y;
  logic signed [POS_W-1:0] smooth_z;
  logic                    last;

  modport source (output valid, kind, status, slot, active, owner_id,
                  smooth_x, smooth_y, smooth_z, last, input ready);
  modport sink   (input valid, kind, status, slot, active, owner_id,
                  smooth_x, smooth_y, smooth_z, last, output ready);
endinterface

/* hw/rtl/apt_slot_store.sv */
// Slot record memory: one write port, one read port with registered read data.
module apt_slot_store import apt_pkg::*; (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [SLOT_W-1:0] wr_addr_i,
  input  slot_entry_t       wr_data_i,
  input  logic              rd_en_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  output slot_entry_t       rd_data_o
);

  slot_entry_t mem_q [SLOTS];
  slot_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/apt_approach.sv */
// One axis of the smoothing step: move a quarter of the way to the goal, saturated.
module apt_approach import apt_pkg::*; (
  input  logic signed [POS_W-1:0]   cur_i,
  input  logic signed [COORD_W-1:0] goal_i,
  output logic signed [POS_W-1:0]   next_o
);

  logic signed [CALC_W-1:0] goal_w;
  logic signed [CALC_W-1:0] cur_w;
  logic signed [CALC_W-1:0] diff_w;
  logic signed [CALC_W-1:0] sum_w;

  always_comb begin
    goal_w = CALC_W'(goal_i) <<< FRAC_BITS;
    cur_w  = CALC_W'(cur_i);
    diff_w = goal_w - cur_w;
    sum_w  = cur_w + (diff_w >>> 2);
    next_o = sat_pos(sum_w);
  end

endmodule

/* hw/rtl/aging_position_track_table.sv */
// Top level of the aging position track table: sequencer, lifetimes and result register.
//
// Channels: item_i takes tick, position and clear items; result_o gives the
// results; a transfer happens on a clock edge with valid and ready both high.
// The user must write configuration only while the block is idle, through
// cfg_we_i / cfg_idx_i / cfg_data_i (0 local scene key, 1 invert y, 2 lifetime);
// the block itself does not enforce this. A tick reads every slot record in turn
// from the slot memory, one per cycle unless the result register is stalled,
// ages it, smooths it, writes it back if it stays live and emits one report per
// slot, the final one marked last. A position item scans the memory one slot a
// cycle until its owner is found or all slots are seen, then emits one status
// and, on a refresh or insert, writes the slot back. Clear and other-scene items
// emit one status without a scan.
// Reset empties every slot and loads the register defaults (lifetime 20).
// If the receiver stalls, the result register holds its item and the slot
// sequence waits; no result is lost. A new item is taken only when idle.
module aging_position_track_table import apt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  apt_item_if.sink              item_i,
  apt_result_if.source          result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TICK = 4'b0010,
    S_MSG  = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [KEY_W-1:0]  scene_key_q;
  logic              invert_y_q;
  logic [LIFE_W-1:0] lifetime_q;

  logic [LIFE_W-1:0] life_q [SLOTS];
  logic [LIFE_W-1:0] life_d [SLOTS];

  logic [CNT_W-1:0]  rd_cnt_q, rd_cnt_d;
  logic              dv_q, dv_d;
  logic [SLOT_W-1:0] idx_q, idx_d;

  logic [ID_W-1:0]           cid_q, cid_d;
  logic [STAMP_W-1:0]        stamp_q, stamp_d;
  logic signed [COORD_W-1:0] gx_q, gx_d, gy_q, gy_d, gz_q, gz_d;

  logic              free_found_q, free_found_d;
  logic [SLOT_W-1:0] free_idx_q, free_idx_d;
  status_e           res_status_q, res_status_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  slot_entry_t       cap_q, cap_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_kind_q, out_kind_d;
  logic [STATUS_W-1:0]     out_status_q, out_status_d;
  logic [SLOT_OUT_W-1:0]   out_slot_q, out_slot_d;
  logic                    out_active_q, out_active_d;
  logic [ID_W-1:0]         out_owner_q, out_owner_d;
  logic signed [POS_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d, out_z_q, out_z_d;
  logic                    out_last_q, out_last_d;

  logic              mem_rd_en;
  logic [SLOT_W-1:0] mem_rd_addr;
  slot_entry_t       mem_rd_data;
  logic              mem_wr_en;
  logic [SLOT_W-1:0] mem_wr_addr;
  slot_entry_t       mem_wr_data;

  logic                    out_free;
  logic                    load;
  logic                    accept;
  logic [LIFE_W-1:0]       life_cur;
  logic [LIFE_W-1:0]       life_dec;
  logic                    live_cur;
  logic                    live_next;
  logic                    last_idx;
  logic signed [POS_W-1:0] nx, ny, nz;

  apt_slot_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  apt_approach u_ax (.cur_i(mem_rd_data.cur_x), .goal_i(mem_rd_data.goal_x), .next_o(nx));
  apt_approach u_ay (.cur_i(mem_rd_data.cur_y), .goal_i(mem_rd_data.goal_y), .next_o(ny));
  apt_approach u_az (.cur_i(mem_rd_data.cur_z), .goal_i(mem_rd_data.goal_z), .next_o(nz));

  assign item_i.ready = (state_q == S_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;

  assign life_cur  = life_q[idx_q];
  assign live_cur  = (life_cur != '0);
  assign life_dec  = live_cur ? life_cur - LIFE_W'(1) : '0;
  assign live_next = (life_dec != '0);
  assign last_idx  = (idx_q == SLOT_W'(SLOTS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scene_key_q <= '0;
      invert_y_q  <= 1'b0;
      lifetime_q  <= LIFE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCENE_KEY: scene_key_q <= cfg_data_i[KEY_W-1:0];
        CFG_INVERT_Y:  invert_y_q  <= cfg_data_i[0];
        CFG_LIFETIME:  lifetime_q  <= cfg_data_i[LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    life_d       = life_q;
    rd_cnt_d     = rd_cnt_q;
    dv_d         = dv_q;
    idx_d        = idx_q;
    cid_d        = cid_q;
    stamp_d      = stamp_q;
    gx_d         = gx_q;
    gy_d         = gy_q;
    gz_d         = gz_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    cap_d        = cap_q;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = rd_cnt_q[SLOT_W-1:0];
    mem_wr_en    = 1'b0;
    mem_wr_addr  = idx_q;
    mem_wr_data  = mem_rd_data;
    load         = 1'b0;
    out_kind_d   = 1'b0;
    out_status_d = STATUS_W'(ST_REFRESH);
    out_slot_d   = '0;
    out_active_d = 1'b0;
    out_owner_d  = '0;
    out_x_d      = '0;
    out_y_d      = '0;
    out_z_d      = '0;
    out_last_d   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rd_cnt_d     = '0;
          dv_d         = 1'b0;
          free_found_d = 1'b0;
          cid_d        = item_i.client_id;
          stamp_d      = item_i.frame_stamp;
          gx_d         = item_i.coord_x;
          gy_d         = invert_y_q ? -item_i.coord_y : item_i.coord_y;
          gz_d         = item_i.coord_z;
          case (item_i.action)
            ACT_TICK: state_d = S_TICK;
            ACT_MSG: begin
              if (item_i.scene_key != scene_key_q) begin
                res_status_d = ST_OTHER;
                state_d      = S_RESP;
              end else begin
                state_d = S_MSG;
              end
            end
            ACT_CLEAR: begin
              for (int i = 0; i < SLOTS; i++) begin
                life_d[i] = '0;
              end
              res_status_d = ST_CLEARED;
              state_d      = S_RESP;
            end
            default: ;
          endcase
        end
      end

      // Write-back goes to idx_q while the read fetches a later slot: no overlap.
      S_TICK: begin
        if (!dv_q || out_free) begin
          if (dv_q) begin
            life_d[idx_q]     = life_dec;
            mem_wr_en         = live_next;
            mem_wr_data.cur_x = nx;
            mem_wr_data.cur_y = ny;
            mem_wr_data.cur_z = nz;
            load              = 1'b1;
            out_kind_d        = 1'b1;
            out_slot_d        = SLOT_OUT_W'(idx_q);
            out_active_d      = live_next;
            out_last_d        = last_idx;
            if (live_next) begin
              out_owner_d = mem_rd_data.owner;
              out_x_d     = nx;
              out_y_d     = ny;
              out_z_d     = nz;
            end
            if (last_idx) begin
              state_d = S_IDLE;
            end
          end
          if (rd_cnt_q < CNT_W'(SLOTS)) begin
            mem_rd_en = 1'b1;
            rd_cnt_d  = rd_cnt_q + CNT_W'(1);
            dv_d      = 1'b1;
            idx_d     = rd_cnt_q[SLOT_W-1:0];
          end else begin
            dv_d = 1'b0;
          end
        end
      end

      S_MSG: begin
        if (rd_cnt_q < CNT_W'(SLOTS)) begin
          mem_rd_en = 1'b1;
          rd_cnt_d  = rd_cnt_q + CNT_W'(1);
          dv_d      = 1'b1;
          idx_d     = rd_cnt_q[SLOT_W-1:0];
        end else begin
          dv_d = 1'b0;
        end
        if (dv_q) begin
          if (live_cur && mem_rd_data.owner == cid_q) begin
            res_status_d = (stamp_q < mem_rd_data.last_frame) ? ST_STALE : ST_REFRESH;
            res_slot_d   = idx_q;
            cap_d        = mem_rd_data;
            state_d      = S_RESP;
          end else begin
            if (!live_cur && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = idx_q;
            end
            if (last_idx) begin
              res_status_d = (free_found_q || !live_cur) ? ST_INSERT : ST_FULL;
              res_slot_d   = free_found_q ? free_idx_q : idx_q;
              state_d      = S_RESP;
            end
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          load         = 1'b1;
          out_status_d = STATUS_W'(res_status_q);
          state_d      = S_IDLE;
          mem_wr_addr  = res_slot_q;
          case (res_status_q)
            ST_REFRESH: begin
              life_d[res_slot_q] = lifetime_q;
              mem_wr_en          = 1'b1;
              mem_wr_data        = cap_q;
              mem_wr_data.last_frame = stamp_q;
              mem_wr_data.goal_x = gx_q;
              mem_wr_data.goal_y = gy_q;
              mem_wr_data.goal_z = gz_q;
              out_slot_d         = SLOT_OUT_W'(res_slot_q);
              out_active_d       = (lifetime_q != '0);
              if (lifetime_q != '0) begin
                out_owner_d = cap_q.owner;
                out_x_d     = cap_q.cur_x;
                out_y_d     = cap_q.cur_y;
                out_z_d     = cap_q.cur_z;
              end
            end
            ST_INSERT: begin
              life_d[res_slot_q]     = lifetime_q;
              mem_wr_en              = 1'b1;
              mem_wr_data.owner      = cid_q;
              mem_wr_data.last_frame = stamp_q;
              mem_wr_data.cur_x      = to_fixed(gx_q);
              mem_wr_data.cur_y      = to_fixed(gy_q);
              mem_wr_data.cur_z      = to_fixed(gz_q);
              mem_wr_data.goal_x     = gx_q;
              mem_wr_data.goal_y     = gy_q;
              mem_wr_data.goal_z     = gz_q;
              out_slot_d             = SLOT_OUT_W'(res_slot_q);
              out_active_d           = (lifetime_q != '0);
              if (lifetime_q != '0) begin
                out_owner_d = cid_q;
                out_x_d     = mem_wr_data.cur_x;
                out_y_d     = mem_wr_data.cur_y;
                out_z_d     = mem_wr_data.cur_z;
              end
            end
            ST_STALE: begin
              out_slot_d   = SLOT_OUT_W'(res_slot_q);
              out_active_d = 1'b1;
              out_owner_d  = cap_q.owner;
              out_x_d      = cap_q.cur_x;
              out_y_d      = cap_q.cur_y;
              out_z_d      = cap_q.cur_z;
            end
            default: ;
          endcase
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rd_cnt_q     <= '0;
      dv_q         <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        life_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      rd_cnt_q     <= rd_cnt_d;
      dv_q         <= dv_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
      life_q       <= life_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    cid_q        <= cid_d;
    stamp_q      <= stamp_d;
    gx_q         <= gx_d;
    gy_q         <= gy_d;
    gz_q         <= gz_d;
    free_idx_q   <= free_idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    cap_q        <= cap_d;
    if (load) begin
      out_kind_q   <= out_kind_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_active_q <= out_active_d;
      out_owner_q  <= out_owner_d;
      out_x_q      <= out_x_d;
      out_y_q      <= out_y_d;
      out_z_q      <= out_z_d;
      out_last_q   <= out_last_d;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.kind     = out_kind_q;
  assign result_o.status   = out_status_q;
  assign result_o.slot     = out_slot_q;
  assign result_o.active   = out_active_q;
  assign result_o.owner_id = out_owner_q;
  assign result_o.smooth_x = out_x_q;
  assign result_o.smooth_y = out_y_q;
  assign result_o.smooth_z = out_z_q;
  assign result_o.last     = out_last_q;

endmodule

/* hw/rtl/apt_checker.sv */
// Port-level checks of the aging position track table, bound to the top level.
module apt_checker import apt_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic [ACTION_W-1:0]   in_action_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic                  out_kind_i,
  input logic [STATUS_W-1:0]   out_status_i,
  input logic                  out_active_i,
  input logic [ID_W-1:0]       out_owner_i,
  input logic [SLOT_OUT_W-1:0] out_slot_i,
  input logic                  out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_slot_i) &&
    $stable(out_status_i) && $stable(out_owner_i))
    else $error("stalled result changed");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i != ACTION_W'(3)) |=> !in_ready_i)
    else $error("ready while an item is in progress");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_kind_i |-> out_last_i)
    else $error("status result not marked last");

  a_report_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i |-> out_status_i == STATUS_W'(ST_REFRESH))
    else $error("slot report with non-zero status");

  a_dropped_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_kind_i && (out_status_i == STATUS_W'(ST_OTHER) ||
    out_status_i == STATUS_W'(ST_FULL) || out_status_i == STATUS_W'(ST_CLEARED))
    |-> !out_active_i && out_owner_i == '0 && out_slot_i == '0)
    else $error("dropped or clear result carries slot data");

endmodule

bind aging_position_track_table apt_checker u_apt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .in_action_i  (item_i.action),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_kind_i   (result_o.kind),
  .out_status_i (result_o.status),
  .out_active_i (result_o.active),
  .out_owner_i  (result_o.owner_id),
  .out_slot_i   (result_o.slot),
  .out_last_i   (result_o.last)
);

/* tb/aging_position_track_table_tb.sv */
// Self-checking testbench of the aging position track table: directed and random traffic.
`timescale 1ns / 1ps

module aging_position_track_table_tb;
  import apt_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE      = 2'd3;
  localparam logic [STATUS_W-1:0] ST_SLOT_REPORT = 3'd0;
  localparam logic                KIND_STATUS    = 1'b0;
  localparam logic                KIND_REPORT    = 1'b1;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 40;
  localparam int POOL          = 20;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic [ID_W-1:0]           client;
    logic [KEY_W-1:0]          key;
    logic [STAMP_W-1:0]        stamp;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } track_item_t;

  typedef struct packed {
    logic                    kind;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_OUT_W-1:0]   slot;
    logic                    active;
    logic [ID_W-1:0]         owner_id;
    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [POS_W-1:0] sz;
    logic                    last;
  } track_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  apt_item_if   item_if ();
  apt_result_if result_if ();

  aging_position_track_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the table and its registers
  logic [KEY_W-1:0]          scene_key_cfg;
  logic                      invert_cfg;
  logic [LIFE_W-1:0]         lifetime_cfg;
  logic [LIFE_W-1:0]         trk_life  [SLOTS];
  logic [ID_W-1:0]           trk_owner [SLOTS];
  logic [STAMP_W-1:0]        trk_frame [SLOTS];
  logic signed [POS_W-1:0]   trk_pos_x [SLOTS];
  logic signed [POS_W-1:0]   trk_pos_y [SLOTS];
  logic signed [POS_W-1:0]   trk_pos_z [SLOTS];
  logic signed [COORD_W-1:0] trk_goal_x [SLOTS];
  logic signed [COORD_W-1:0] trk_goal_y [SLOTS];
  logic signed [COORD_W-1:0] trk_goal_z [SLOTS];

  track_report_t     expected_reports [$];
  int                errors = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  bit                hold_results = 1'b0;
  logic [ID_W-1:0]   client_pool [POOL];
  logic [STAMP_W-1:0] frame_ctr;

  function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (POS_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return POS_W'(hi);
    if (v < lo) return POS_W'(lo);
    return POS_W'(v);
  endfunction

  // quarter step towards the goal, floor shift
  function automatic logic signed [POS_W-1:0] glide(input logic signed [POS_W-1:0] cur,
                                                    input logic signed [COORD_W-1:0] goal);
    longint diff;
    diff = (longint'(goal) <<< FRAC_BITS) - longint'(cur);
    return clamp_pos(longint'(cur) + (diff >>> 2));
  endfunction

  function automatic track_report_t slot_view(input logic kind, input logic [STATUS_W-1:0] st,
                                              input int idx, input bit show, input bit last);
    track_report_t r;
    r = '0;
    r.kind   = kind;
    r.status = st;
    r.last   = last;
    if (show) begin
      r.slot = SLOT_OUT_W'(idx);
      if (trk_life[idx] != '0) begin
        r.active   = 1'b1;
        r.owner_id = trk_owner[idx];
        r.sx       = trk_pos_x[idx];
        r.sy       = trk_pos_y[idx];
        r.sz       = trk_pos_z[idx];
      end
    end
    return r;
  endfunction

  function automatic void predict_item(input track_item_t it);
    logic signed [COORD_W-1:0] y;
    int free_slot;
    free_slot = -1;
    y = it.y;
    case (it.action)
      ACT_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (trk_life[i] != '0) trk_life[i] = trk_life[i] - 1'b1;
          if (trk_life[i] != '0) begin
            trk_pos_x[i] = glide(trk_pos_x[i], trk_goal_x[i]);
            trk_pos_y[i] = glide(trk_pos_y[i], trk_goal_y[i]);
            trk_pos_z[i] = glide(trk_pos_z[i], trk_goal_z[i]);
          end
        end
        for (int i = 0; i < SLOTS; i++)
          expected_reports.push_back(slot_view(KIND_REPORT, ST_SLOT_REPORT, i, 1'b1,
                                               i == SLOTS - 1));
      end
      ACT_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) trk_life[i] = '0;
        expected_reports.push_back(slot_view(KIND_STATUS, ST_CLEARED, 0, 1'b0, 1'b1));
      end
      ACT_MSG: begin
        if (it.key != scene_key_cfg) begin
          expected_reports.push_back(slot_view(KIND_STATUS, ST_OTHER, 0, 1'b0, 1'b1));
          return;
        end
        if (invert_cfg) y = -it.y;
        for (int i = 0; i < SLOTS; i++) begin
          if (trk_life[i] != '0 && trk_owner[i] == it.client) begin
            if (it.stamp < trk_frame[i]) begin
              expected_reports.push_back(slot_view(KIND_STATUS, ST_STALE, i, 1'b1, 1'b1));
            end else begin
              trk_life[i]   = lifetime_cfg;
              trk_frame[i]  = it.stamp;
              trk_goal_x[i] = it.x;
              trk_goal_y[i] = y;
              trk_goal_z[i] = it.z;
              expected_reports.push_back(slot_view(KIND_STATUS, ST_REFRESH, i, 1'b1, 1'b1));
            end
            return;
          end
          if (trk_life[i] == '0 && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) begin
          expected_reports.push_back(slot_view(KIND_STATUS, ST_FULL, 0, 1'b0, 1'b1));
          return;
        end
        trk_life[free_slot]   = lifetime_cfg;
        trk_owner[free_slot]  = it.client;
        trk_frame[free_slot]  = it.stamp;
        trk_goal_x[free_slot] = it.x;
        trk_goal_y[free_slot] = y;
        trk_goal_z[free_slot] = it.z;
        trk_pos_x[free_slot]  = clamp_pos(longint'(it.x) <<< FRAC_BITS);
        trk_pos_y[free_slot]  = clamp_pos(longint'(y) <<< FRAC_BITS);
        trk_pos_z[free_slot]  = clamp_pos(longint'(it.z) <<< FRAC_BITS);
        expected_reports.push_back(slot_view(KIND_STATUS, ST_INSERT, free_slot, 1'b1, 1'b1));
      end
      default: ;
    endcase
  endfunction

  function automatic track_item_t op_item(input logic [ACTION_W-1:0] act);
    track_item_t it;
    it.action = act;
    it.client = ID_W'($urandom);
    it.key    = KEY_W'($urandom);
    it.stamp  = $urandom;
    it.x      = COORD_W'($urandom);
    it.y      = COORD_W'($urandom);
    it.z      = COORD_W'($urandom);
    return it;
  endfunction

  function automatic track_item_t pos_msg(input logic [ID_W-1:0] client,
                                          input logic [KEY_W-1:0] key,
                                          input logic [STAMP_W-1:0] stamp,
                                          input logic signed [COORD_W-1:0] x,
                                          input logic signed [COORD_W-1:0] y,
                                          input logic signed [COORD_W-1:0] z);
    track_item_t it;
    it.action = ACT_MSG;
    it.client = client;
    it.key    = key;
    it.stamp  = stamp;
    it.x      = x;
    it.y      = y;
    it.z      = z;
    return it;
  endfunction

  function automatic logic signed [COORD_W-1:0] edge_coord();
    case ($urandom_range(2))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'sh0000;
    endcase
  endfunction

  // mostly well-formed traffic from a small client pool, some noise
  function automatic track_item_t next_random_item();
    track_item_t it;
    int pick;
    it = op_item(ACT_MSG);
    pick = $urandom_range(99);
    if (pick < 18) begin
      it.action = ACT_TICK;
    end else if (pick < 20) begin
      it.action = ACT_CLEAR;
    end else if (pick < 23) begin
      it.action = ACT_SPARE;
    end else if (pick >= 28) begin
      it.key = scene_key_cfg;
      it.client = client_pool[$urandom_range(POOL - 1)];
      frame_ctr = frame_ctr + $urandom_range(3);
      it.stamp = frame_ctr;
      if ($urandom_range(9) == 0) it.stamp = frame_ctr - $urandom_range(1, 500);
      if ($urandom_range(5) == 0) it.x = edge_coord();
      if ($urandom_range(5) == 0) it.y = edge_coord();
      if ($urandom_range(5) == 0) it.z = edge_coord();
    end
    return it;
  endfunction

  function automatic string show_report(input track_report_t r);
    return $sformatf("kind=%0d st=%0d slot=%0d act=%0d id=%h x=%0d y=%0d z=%0d last=%0d",
                     r.kind, r.status, r.slot, r.active, r.owner_id, r.sx, r.sy, r.sz, r.last);
  endfunction

  function automatic bit reports_differ(input track_report_t a, input track_report_t b);
    return (a.kind !== b.kind) || (a.status !== b.status) || (a.slot !== b.slot) ||
           (a.active !== b.active) || (a.owner_id !== b.owner_id) || (a.sx !== b.sx) ||
           (a.sy !== b.sy) || (a.sz !== b.sz) || (a.last !== b.last);
  endfunction

  task automatic offer_item(input track_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.action      <= it.action;
    item_if.client_id   <= it.client;
    item_if.scene_key   <= it.key;
    item_if.frame_stamp <= it.stamp;
    item_if.coord_x     <= it.x;
    item_if.coord_y     <= it.y;
    item_if.coord_z     <= it.z;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    predict_item(it);
  endtask

  task automatic settle();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic load_config(input logic [KEY_W-1:0] key, input logic inv,
                             input logic [LIFE_W-1:0] life);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SCENE_KEY;
    cfg_data <= key;
    @(negedge clk_i);
    cfg_idx  <= CFG_INVERT_Y;
    cfg_data <= CFG_DATA_W'(inv);
    @(negedge clk_i);
    cfg_idx  <= CFG_LIFETIME;
    cfg_data <= CFG_DATA_W'(life);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    scene_key_cfg = key;
    invert_cfg    = inv;
    lifetime_cfg  = life;
  endtask

  // reset defaults: scene key 0, no inversion, lifetime 20
  task automatic test_positions();
    offer_item(pos_msg(16'h0000, 16'h0000, 32'h0, 16'sh8000, 16'sh7FFF, 16'sh0000));
    offer_item(pos_msg(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, -16'sd1));
    offer_item(pos_msg(16'h0000, 16'h0000, 32'd5, 16'sd100, -16'sd200, 16'sd300));
    offer_item(pos_msg(16'h0000, 16'h0000, 32'd4, 16'sd1, 16'sd1, 16'sd1));
    offer_item(pos_msg(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, -16'sd7, 16'sd9, 16'sh8000));
    offer_item(pos_msg(16'h0001, 16'hFFFF, 32'd1, 16'sd0, 16'sd0, 16'sd0));
    offer_item(op_item(ACT_TICK));
    offer_item(op_item(ACT_SPARE));
    offer_item(op_item(ACT_CLEAR));
    offer_item(op_item(ACT_TICK));
    settle();
  endtask

  // sixteen inserts then one refused; y negation at both ends of the range
  task automatic test_full_table();
    load_config(16'hFFFF, 1'b1, 8'hFF);
    for (int i = 0; i <= SLOTS; i++)
      offer_item(pos_msg(ID_W'(i * 4097), 16'hFFFF, $urandom, COORD_W'($urandom),
                         (i % 2 != 0) ? 16'sh8000 : 16'sh7FFF, COORD_W'($urandom)));
    offer_item(pos_msg(16'h1234, 16'h0000, 32'd0, 16'sd0, 16'sd0, 16'sd0));
    offer_item(op_item(ACT_TICK));
    offer_item(op_item(ACT_CLEAR));
    settle();
  endtask

  task automatic test_lifetime_edges();
    logic [KEY_W-1:0] key;
    key = KEY_W'($urandom);
    load_config(key, 1'b0, 8'd0);
    offer_item(pos_msg(16'hA5A5, key, 32'd10, 16'sd5, 16'sd6, 16'sd7));
    offer_item(pos_msg(16'hA5A5, key, 32'd11, 16'sd8, 16'sd9, 16'sd10));
    offer_item(op_item(ACT_TICK));
    settle();
    load_config(key, 1'b1, 8'd1);
    offer_item(pos_msg(16'h5A5A, key, 32'd3, -16'sd4, 16'sh8000, 16'sd4));
    offer_item(op_item(ACT_TICK));
    offer_item(pos_msg(16'h5A5A, key, 32'd1, 16'sd2, 16'sd3, -16'sd2));
    settle();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [KEY_W-1:0] key, input logic inv,
                                   input logic [LIFE_W-1:0] life);
    track_item_t it;
    int sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    load_config(key, inv, life);
    foreach (client_pool[i]) client_pool[i] = ID_W'($urandom);
    frame_ctr = $urandom;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      it = next_random_item();
      offer_item(it);
      if (it.action != ACT_SPARE) sent++;
    end
    settle();
  endtask

  // receiver holds off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    logic [KEY_W-1:0] key;
    key = KEY_W'($urandom);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_config(key, 1'b0, 8'd30);
    fork
      begin
        @(posedge clk_i);
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end
      begin
        for (int i = 0; i < 4; i++)
          offer_item(pos_msg(ID_W'($urandom), key, $urandom, COORD_W'($urandom),
                             COORD_W'($urandom), COORD_W'($urandom)));
        repeat (3) offer_item(op_item(ACT_TICK));
      end
    join
    settle();
  endtask

  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_if.ready <= !hold_results && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    track_report_t seen;
    track_report_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      seen.kind     = result_if.kind;
      seen.status   = result_if.status;
      seen.slot     = result_if.slot;
      seen.active   = result_if.active;
      seen.owner_id = result_if.owner_id;
      seen.sx       = result_if.smooth_x;
      seen.sy       = result_if.smooth_y;
      seen.sz       = result_if.smooth_z;
      seen.last     = result_if.last;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", show_report(seen));
      end else begin
        want = expected_reports.pop_front();
        if (reports_differ(want, seen)) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp %s", show_report(want));
            $display("          got %s", show_report(seen));
          end
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_SCENE_KEY;
    cfg_data            = '0;
    item_if.valid       = 1'b0;
    item_if.action      = ACT_TICK;
    item_if.client_id   = '0;
    item_if.scene_key   = '0;
    item_if.frame_stamp = '0;
    item_if.coord_x     = '0;
    item_if.coord_y     = '0;
    item_if.coord_z     = '0;
    scene_key_cfg       = '0;
    invert_cfg          = 1'b0;
    lifetime_cfg        = LIFE_RESET;
    foreach (trk_life[i]) trk_life[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_positions();
    test_full_table();
    test_lifetime_edges();
    test_random_phase(0, 0, KEY_W'($urandom), 1'b0, 8'hFF);
    test_random_phase(73, 0, 16'hFFFF, 1'b1, 8'd6);
    test_random_phase(0, 73, 16'h0000, 1'b1, 8'd1);
    test_random_phase(7, 7, KEY_W'($urandom), 1'b0, LIFE_W'($urandom_range(2, 40)));
    test_backpressure();

    errors += expected_reports.size();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
